@@ design/fft512_power_spectrum_defines.svh @@
// Assertion macros used by the power spectrum engine (fps_back)
`ifndef FFT512_POWER_SPECTRUM_DEFINES_SVH
`define FFT512_POWER_SPECTRUM_DEFINES_SVH
`ifndef SYNTH
`define FPS_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("fft512_power_spectrum: check failed");
`define FPS_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fft512_power_spectrum: check failed");
`define FPS_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fft512_power_spectrum: check failed");
`else
`define FPS_ASSERT(lbl, cond)
`define FPS_IMPLIES(lbl, ante, cons)
`define FPS_NEXT(lbl, ante, cons)
`endif
`endif

@@ design/fps_pkg.sv @@
// Types, constants and twiddle table of the power spectrum block
package fps_pkg;
	localparam int FFT_LEN   = 512;
	localparam int FRAME_LEN = 400;
	localparam int DATA_W    = 24;
	localparam int TW_W      = 16;
	localparam int SMP_W     = 16;
	localparam int BIN_W     = 9;
	localparam int PWR_W     = 48;
	localparam int LOG_N     = $clog2(FFT_LEN);
	localparam int ADDR_W    = LOG_N;
	localparam int HALF      = FFT_LEN / 2;
	localparam int OCT       = FFT_LEN / 8;
	localparam int CNT_W     = $clog2(FRAME_LEN + 1);
	localparam int STG_W     = $clog2(LOG_N);
	localparam int PROD_W    = DATA_W + TW_W;
	localparam int NET       = 2 * LOG_N - 2 * (DATA_W - 16);
	localparam logic [PWR_W-1:0] PWR_MAX = {PWR_W{1'b1}};
	localparam logic [PWR_W-1:0] PWR_LIM = PWR_MAX >> NET;
	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	typedef struct packed {
		logic                    func;
		logic signed [SMP_W-1:0] sample;
		logic [BIN_W-1:0]        bin;
	} fps_req_t;

	typedef struct packed {
		logic [PWR_W-1:0] power;
		logic [BIN_W-1:0] bin_out;
		logic             ready_res;
	} fps_rsp_t;

	// head of the request queue as seen by the back end
	typedef struct packed {
		logic     valid;
		fps_req_t item;
	} fps_head_t;

	typedef logic [HALF-1:0][2*TW_W-1:0] fps_tw_rom_t;

	// unsigned quotient by shift and subtract, used only to build the table
	function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = 64'd0;
		rem = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			rem = (rem << 1) | longint'(num[b]);
			if (rem >= den) begin
				rem = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Q30 Taylor series of cos or sin over the first octant
	function automatic longint unsigned trig_q30(longint unsigned x, bit want_sin);
		longint unsigned x2;
		longint unsigned term;
		longint unsigned d;
		longint          acc;
		x2 = (x * x) >> 30;
		term = want_sin ? x : ONE_Q30;
		acc = longint'(term);
		for (int n = 1; n <= 7; n++) begin
			d = want_sin ? longint'(2 * n) * longint'(2 * n + 1)
			             : longint'(2 * n - 1) * longint'(2 * n);
			term = udiv((term * x2) >> 30, d);
			acc = ((n & 1) == 1) ? acc - longint'(term) : acc + longint'(term);
		end
		return (acc < 0) ? 64'd0 : longint'(acc);
	endfunction

	function automatic logic signed [TW_W-1:0] round_tw(longint unsigned q30);
		longint unsigned q;
		longint unsigned mx;
		q = (q30 + (64'd1 << (30 - TW_W))) >> (31 - TW_W);
		mx = (64'd1 << (TW_W - 1)) - 64'd1;
		return TW_W'((q > mx) ? mx : q);
	endfunction

	// twiddle k: {cos(2 pi k/N), -sin(2 pi k/N)} packed re over im
	function automatic fps_tw_rom_t build_tw();
		fps_tw_rom_t             rom;
		int                      q;
		int                      m;
		bit                      swap;
		bit                      neg_cos;
		longint unsigned         x;
		logic signed [TW_W-1:0]  c;
		logic signed [TW_W-1:0]  s;
		logic signed [TW_W-1:0]  cv;
		logic signed [TW_W-1:0]  sv;
		q = OCT;
		for (int k = 0; k < HALF; k++) begin
			if (k <= q) begin
				m = k; swap = 0; neg_cos = 0;
			end else if (k <= 2 * q) begin
				m = 2 * q - k; swap = 1; neg_cos = 0;
			end else if (k <= 3 * q) begin
				m = k - 2 * q; swap = 1; neg_cos = 1;
			end else begin
				m = 4 * q - k; swap = 0; neg_cos = 1;
			end
			x = (64'd2 * PI_Q30 * longint'(m) + longint'(HALF)) >> LOG_N;
			c = round_tw(trig_q30(x, 1'b0));
			s = round_tw(trig_q30(x, 1'b1));
			cv = swap ? s : c;
			sv = swap ? c : s;
			rom[k] = {(neg_cos ? -cv : cv), -sv};
		end
		return rom;
	endfunction

	localparam fps_tw_rom_t TW_ROM = build_tw();

	function automatic logic [ADDR_W-1:0] bitrev(logic [ADDR_W-1:0] v);
		logic [ADDR_W-1:0] r;
		for (int b = 0; b < ADDR_W; b++) begin
			r[ADDR_W-1-b] = v[b];
		end
		return r;
	endfunction
endpackage

@@ design/fps_ram.sv @@
// Generic simple dual-port RAM with registered read
module fps_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ design/fps_front.sv @@
// Request intake: two-entry queue ahead of the transform engine
module fps_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  fps_pkg::fps_req_t  req,
	output fps_pkg::fps_head_t head,
	input  logic               pop
);
	fps_pkg::fps_req_t ent_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        fill_q;
	logic              push;
	logic              take;

	assign req_ready  = (fill_q != 2'd2);
	assign push       = req_valid && req_ready;
	assign take       = pop && (fill_q != 2'd0);
	assign head.valid = (fill_q != 2'd0);
	assign head.item  = ent_q[rd_ptr_q];

	// store incoming request
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= req;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, take};
		end
	end
endmodule

@@ design/fps_back.sv @@
// Transform engine: sample store, butterfly sequencer, power table, read path
`include "fft512_power_spectrum_defines.svh"
module fps_back (
	input  logic               clk,
	input  logic               arst_n,
	input  fps_pkg::fps_head_t head,
	output logic               pop,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output fps_pkg::fps_rsp_t  rsp
);
	localparam int AW = fps_pkg::ADDR_W;
	localparam int DW = fps_pkg::DATA_W;
	localparam int PW = fps_pkg::PROD_W;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_PAD    = 12'b000000000010,
		S_BF_RDU = 12'b000000000100,
		S_BF_RDL = 12'b000000001000,
		S_BF_ADD = 12'b000000010000,
		S_BF_MUL = 12'b000000100000,
		S_BF_SUM = 12'b000001000000,
		S_PW_RD  = 12'b000010000000,
		S_PW_SQ  = 12'b000100000000,
		S_PW_WR  = 12'b001000000000,
		S_RD_WT  = 12'b010000000000,
		S_SPARE  = 12'b100000000000
	} fps_state_t;

	fps_state_t                      state_q;
	logic [fps_pkg::CNT_W-1:0]       cnt_q;
	logic [fps_pkg::STG_W-1:0]       stage_q;
	logic [AW-2:0]                   bfly_q;
	logic [AW-1:0]                   idx_q;
	logic                            frame_done_q;
	logic [fps_pkg::BIN_W-1:0]       bin_q;
	logic                            rsp_valid_q;
	fps_pkg::fps_rsp_t               rsp_q;
	logic [2*DW-1:0]                 u_q;
	logic [2*DW-1:0]                 a_s1;
	logic signed [DW-1:0]            c_re_s1;
	logic signed [DW-1:0]            c_im_s1;
	logic signed [PW-1:0]            p_rr_s2;
	logic signed [PW-1:0]            p_ii_s2;
	logic signed [PW-1:0]            p_ri_s2;
	logic signed [PW-1:0]            p_ir_s2;
	logic [fps_pkg::PWR_W-1:0]       sq_re_s1;
	logic [fps_pkg::PWR_W-1:0]       sq_im_s1;

	logic                            wk_we;
	logic [AW-1:0]                   wk_wa;
	logic [2*DW-1:0]                 wk_wd;
	logic [AW-1:0]                   wk_ra;
	logic [2*DW-1:0]                 wk_rd;
	logic                            pw_we;
	logic [fps_pkg::PWR_W-1:0]       pw_wd;
	logic [AW-1:0]                   pw_ra;
	logic [fps_pkg::PWR_W-1:0]       pw_rd;

	logic [AW-1:0]                   half_w;
	logic [AW-1:0]                   j_w;
	logic [AW-1:0]                   grp_mask;
	logic [AW-1:0]                   u_addr;
	logic [AW-1:0]                   l_addr;
	logic [AW-1:0]                   tw_full;
	logic signed [fps_pkg::TW_W-1:0] tw_re;
	logic signed [fps_pkg::TW_W-1:0] tw_im;
	logic signed [DW:0]              sum_re;
	logic signed [DW:0]              sum_im;
	logic signed [DW:0]              dif_re;
	logic signed [DW:0]              dif_im;
	logic signed [PW:0]              br_sum;
	logic signed [PW:0]              bi_sum;
	logic signed [PW:0]              br_sh;
	logic signed [PW:0]              bi_sh;
	logic [DW-1:0]                   br_sat;
	logic [DW-1:0]                   bi_sat;
	logic signed [DW-1:0]            pw_re;
	logic signed [DW-1:0]            pw_im;
	logic [fps_pkg::PWR_W:0]         sq_sum;
	logic [fps_pkg::PWR_W-1:0]       pwr_val;
	logic                            take_push;
	logic                            take_read;

	fps_ram #(.WIDTH(2 * DW), .DEPTH(fps_pkg::FFT_LEN)) u_work (
		.clk(clk), .we(wk_we), .waddr(wk_wa), .wdata(wk_wd), .raddr(wk_ra), .rdata(wk_rd)
	);

	fps_ram #(.WIDTH(fps_pkg::PWR_W), .DEPTH(fps_pkg::FFT_LEN)) u_power (
		.clk(clk), .we(pw_we), .waddr(idx_q), .wdata(pw_wd), .raddr(pw_ra), .rdata(pw_rd)
	);

	// butterfly addressing for the current stage
	assign half_w   = AW'(fps_pkg::HALF) >> stage_q;
	assign j_w      = {1'b0, bfly_q} & (half_w - AW'(1));
	assign grp_mask = ~((half_w << 1) - AW'(1));
	assign u_addr   = ({bfly_q, 1'b0} & grp_mask) | j_w;
	assign l_addr   = u_addr | half_w;
	assign tw_full  = j_w << stage_q;
	assign tw_re    = $signed(fps_pkg::TW_ROM[tw_full[AW-2:0]][2*fps_pkg::TW_W-1:fps_pkg::TW_W]);
	assign tw_im    = $signed(fps_pkg::TW_ROM[tw_full[AW-2:0]][fps_pkg::TW_W-1:0]);

	// halved sum and difference of the upper and lower points
	assign sum_re = $signed({u_q[2*DW-1], u_q[2*DW-1:DW]}) + $signed({wk_rd[2*DW-1], wk_rd[2*DW-1:DW]});
	assign sum_im = $signed({u_q[DW-1], u_q[DW-1:0]}) + $signed({wk_rd[DW-1], wk_rd[DW-1:0]});
	assign dif_re = $signed({u_q[2*DW-1], u_q[2*DW-1:DW]}) - $signed({wk_rd[2*DW-1], wk_rd[2*DW-1:DW]});
	assign dif_im = $signed({u_q[DW-1], u_q[DW-1:0]}) - $signed({wk_rd[DW-1], wk_rd[DW-1:0]});

	// twiddle product, truncate and saturate
	assign br_sum = $signed({p_rr_s2[PW-1], p_rr_s2}) - $signed({p_ii_s2[PW-1], p_ii_s2});
	assign bi_sum = $signed({p_ri_s2[PW-1], p_ri_s2}) + $signed({p_ir_s2[PW-1], p_ir_s2});
	assign br_sh  = br_sum >>> (fps_pkg::TW_W - 1);
	assign bi_sh  = bi_sum >>> (fps_pkg::TW_W - 1);
	assign br_sat = ((&br_sh[PW:DW-1]) || !(|br_sh[PW:DW-1])) ? br_sh[DW-1:0]
	              : (br_sh[PW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}});
	assign bi_sat = ((&bi_sh[PW:DW-1]) || !(|bi_sh[PW:DW-1])) ? bi_sh[DW-1:0]
	              : (bi_sh[PW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}});

	// bin power, rescaled and clipped to the output range
	assign pw_re   = $signed(wk_rd[2*DW-1:DW]);
	assign pw_im   = $signed(wk_rd[DW-1:0]);
	assign sq_sum  = {1'b0, sq_re_s1} + {1'b0, sq_im_s1};
	assign pwr_val = (sq_sum > {1'b0, fps_pkg::PWR_LIM}) ? fps_pkg::PWR_MAX
	               : fps_pkg::PWR_W'(sq_sum << fps_pkg::NET);

	assign take_push = (state_q == S_IDLE) && head.valid && !head.item.func;
	assign take_read = (state_q == S_IDLE) && head.valid && head.item.func && !rsp_valid_q;
	assign pop       = take_push || take_read;

	// drive memory ports from the sequencer state
	always_comb begin
		wk_we = 1'b0;
		wk_wa = u_addr;
		wk_wd = a_s1;
		wk_ra = u_addr;
		pw_we = 1'b0;
		pw_wd = pwr_val;
		pw_ra = head.item.bin;
		case (state_q)
			S_IDLE: begin
				if (take_push && (fps_pkg::CNT_W'(fps_pkg::FFT_LEN) > cnt_q
				                  || fps_pkg::FRAME_LEN <= fps_pkg::FFT_LEN)) begin
					wk_we = 1'b1;
					wk_wa = AW'(cnt_q);
					wk_wd = {DW'(head.item.sample) << (DW - fps_pkg::SMP_W), {DW{1'b0}}};
				end
			end
			S_PAD: begin
				wk_we = 1'b1;
				wk_wa = idx_q;
				wk_wd = '0;
			end
			S_BF_RDL: wk_ra = l_addr;
			S_BF_MUL: wk_we = 1'b1;
			S_BF_SUM: begin
				wk_we = 1'b1;
				wk_wa = l_addr;
				wk_wd = {br_sat, bi_sat};
			end
			S_PW_RD: wk_ra = fps_pkg::bitrev(idx_q);
			S_PW_WR: pw_we = 1'b1;
			default: ;
		endcase
	end

	// hold datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_BF_RDL: u_q <= wk_rd;
			S_BF_ADD: begin
				a_s1    <= {sum_re[DW:1], sum_im[DW:1]};
				c_re_s1 <= dif_re[DW:1];
				c_im_s1 <= dif_im[DW:1];
			end
			S_BF_MUL: begin
				p_rr_s2 <= c_re_s1 * tw_re;
				p_ii_s2 <= c_im_s1 * tw_im;
				p_ri_s2 <= c_re_s1 * tw_im;
				p_ir_s2 <= c_im_s1 * tw_re;
			end
			S_PW_SQ: begin
				sq_re_s1 <= fps_pkg::PWR_W'(pw_re * pw_re);
				sq_im_s1 <= fps_pkg::PWR_W'(pw_im * pw_im);
			end
			S_IDLE: bin_q <= head.item.bin;
			default: ;
		endcase
	end

	// advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			stage_q      <= '0;
			bfly_q       <= '0;
			idx_q        <= '0;
			frame_done_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take_push) begin
						if (cnt_q == fps_pkg::CNT_W'(fps_pkg::FRAME_LEN - 1)) begin
							cnt_q   <= '0;
							stage_q <= '0;
							bfly_q  <= '0;
							if (fps_pkg::FRAME_LEN < fps_pkg::FFT_LEN) begin
								idx_q   <= AW'(fps_pkg::FRAME_LEN);
								state_q <= S_PAD;
							end else begin
								state_q <= S_BF_RDU;
							end
						end else begin
							cnt_q <= cnt_q + fps_pkg::CNT_W'(1);
						end
					end else if (take_read) begin
						if (frame_done_q) begin
							state_q <= S_RD_WT;
						end else begin
							rsp_q       <= '{power: '0, bin_out: head.item.bin, ready_res: 1'b0};
							rsp_valid_q <= 1'b1;
						end
					end
				end
				S_PAD: begin
					idx_q <= idx_q + AW'(1);
					if (&idx_q) begin
						state_q <= S_BF_RDU;
					end
				end
				S_BF_RDU: state_q <= S_BF_RDL;
				S_BF_RDL: state_q <= S_BF_ADD;
				S_BF_ADD: state_q <= S_BF_MUL;
				S_BF_MUL: state_q <= S_BF_SUM;
				S_BF_SUM: begin
					bfly_q <= bfly_q + (AW-1)'(1);
					if (&bfly_q) begin
						if (stage_q == fps_pkg::STG_W'(fps_pkg::LOG_N - 1)) begin
							idx_q   <= '0;
							state_q <= S_PW_RD;
						end else begin
							stage_q <= stage_q + fps_pkg::STG_W'(1);
							state_q <= S_BF_RDU;
						end
					end else begin
						state_q <= S_BF_RDU;
					end
				end
				S_PW_RD: state_q <= S_PW_SQ;
				S_PW_SQ: state_q <= S_PW_WR;
				S_PW_WR: begin
					idx_q <= idx_q + AW'(1);
					if (&idx_q) begin
						frame_done_q <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_PW_RD;
					end
				end
				S_RD_WT: begin
					rsp_q       <= '{power: pw_rd, bin_out: bin_q, ready_res: 1'b1};
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`FPS_IMPLIES(a_pop_idle, pop, state_q == S_IDLE)
	`FPS_IMPLIES(a_rdy_done, rsp_valid_q && rsp_q.ready_res, frame_done_q)
	`FPS_IMPLIES(a_zero_pwr, rsp_valid_q && !rsp_q.ready_res, rsp_q.power == '0)
	`FPS_ASSERT(a_cnt_range, cnt_q < fps_pkg::CNT_W'(fps_pkg::FRAME_LEN))
	`FPS_NEXT(a_read_wait, state_q == S_RD_WT, rsp_valid_q && rsp_q.ready_res)
endmodule

@@ design/fft512_power_spectrum.sv @@
// Power spectrum of a 400-sample frame via a 512-point fixed-point FFT
// Usage:
//   Requests arrive on req_valid/req_ready with payload req. func 0 pushes one
//   Q1.15 sample; func 1 reads the power of one bin. A push gives no response,
//   a read gives one response on rsp_valid/rsp_ready with power, bin echo and
//   a flag that is set once a frame has been transformed.
//   A two-entry queue takes requests while the engine is busy.
//   A push is taken in the idle state; a read before the first frame is
//   answered from idle, one after it through a wait state for the registered
//   power table read. The push that completes a frame starts the transform:
//   zero padding of the last 112 points, 9 stages of 256 butterflies (read
//   upper, read lower, add, multiply, write back) through one shared complex
//   multiply unit and the one-read one-write work memory, then 512 bins (read,
//   square, write) to form the power table, while further requests wait in
//   the queue. Reset clears the sample count and the frame flag; reads then
//   return zero power until the first frame finishes.
//   A stalled response holds the next read at the head of the queue, and the
//   requests behind it wait; pushes at the head carry on.
module fft512_power_spectrum (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  fps_pkg::fps_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output fps_pkg::fps_rsp_t rsp
);
	fps_pkg::fps_head_t head;
	logic               pop;

	fps_front u_front (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
		.req(req), .head(head), .pop(pop)
	);

	fps_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .pop(pop),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);
endmodule

@@ tb/fps_checker.sv @@
// Spectrum predictor and response checker for the power spectrum block
module fps_checker
	import fps_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_ready,
	input  fps_req_t req,
	input  logic     rsp_valid,
	input  logic     rsp_ready,
	input  fps_rsp_t rsp,
	output int       fails,
	output int       pending
);
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_READ = 1'b1;
	localparam longint unsigned ONE_Q = 64'd1 << 30;
	localparam longint unsigned PI_Q  = 64'd3373259426;
	localparam longint unsigned P48   = (64'd1 << 48) - 1;

	longint          frame_re [FFT_LEN];
	longint          frame_im [FFT_LEN];
	longint unsigned bin_power [FFT_LEN];
	longint          rot_re [HALF];
	longint          rot_im [HALF];
	int              samples_in;
	bit              spectrum_valid;
	fps_rsp_t        read_results [$];

	// Taylor series in Q30 over the first octant
	function automatic longint series_q30(longint unsigned x, bit odd);
		longint unsigned sq, t, dv;
		longint          acc;
		sq = (x * x) >> 30;
		t = odd ? x : ONE_Q;
		acc = t;
		for (int n = 1; n < 8; n++) begin
			dv = odd ? (2 * n) * (2 * n + 1) : (2 * n - 1) * (2 * n);
			t = ((t * sq) >> 30) / dv;
			if (n % 2) acc -= t;
			else acc += t;
		end
		return (acc < 0) ? 0 : acc;
	endfunction

	function automatic longint to_q15(longint v);
		longint r;
		r = (v + (64'd1 << 14)) >>> 15;
		return (r > 32767) ? 32767 : r;
	endfunction

	// fill the rotation table by octant symmetry
	function automatic void make_rotations();
		int              oct, m;
		bit              flip, neg;
		longint unsigned ang;
		longint          cs, sn, a, b;
		oct = FFT_LEN / 8;
		for (int k = 0; k < HALF; k++) begin
			flip = (k > oct && k <= 3 * oct);
			neg  = (k > 2 * oct);
			if (k <= oct) m = k;
			else if (k <= 2 * oct) m = 2 * oct - k;
			else if (k <= 3 * oct) m = k - 2 * oct;
			else m = 4 * oct - k;
			ang = (2 * PI_Q * m + FFT_LEN / 2) / FFT_LEN;
			cs = to_q15(series_q30(ang, 1'b0));
			sn = to_q15(series_q30(ang, 1'b1));
			a = flip ? sn : cs;
			b = flip ? cs : sn;
			rot_re[k] = neg ? -a : a;
			rot_im[k] = -b;
		end
	endfunction

	function automatic longint clip24(longint v);
		longint hi;
		hi = (64'd1 << (DATA_W - 1)) - 1;
		return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
	endfunction

	// zero-pad, run the halving DIF butterflies, then form bin powers
	function automatic void run_spectrum();
		int              half, u, l, tw, r;
		longint          ar, ai, cr, ci;
		longint unsigned pw;
		for (int i = FRAME_LEN; i < FFT_LEN; i++) begin
			frame_re[i] = 0;
			frame_im[i] = 0;
		end
		for (int s = 0; s < LOG_N; s++) begin
			half = FFT_LEN >> (s + 1);
			for (int base = 0; base < FFT_LEN; base += 2 * half) begin
				for (int j = 0; j < half; j++) begin
					u = base + j;
					l = u + half;
					tw = (j << s) & (HALF - 1);
					ar = (frame_re[u] + frame_re[l]) >>> 1;
					ai = (frame_im[u] + frame_im[l]) >>> 1;
					cr = (frame_re[u] - frame_re[l]) >>> 1;
					ci = (frame_im[u] - frame_im[l]) >>> 1;
					frame_re[u] = ar;
					frame_im[u] = ai;
					frame_re[l] = clip24((cr * rot_re[tw] - ci * rot_im[tw]) >>> 15);
					frame_im[l] = clip24((cr * rot_im[tw] + ci * rot_re[tw]) >>> 15);
				end
			end
		end
		for (int i = 0; i < FFT_LEN; i++) begin
			r = 0;
			for (int b = 0; b < LOG_N; b++) r |= ((i >> b) & 1) << (LOG_N - 1 - b);
			pw = frame_re[r] * frame_re[r] + frame_im[r] * frame_im[r];
			bin_power[i] = (pw > (P48 >> 2)) ? P48 : (pw << 2);
		end
	endfunction

	initial begin
		make_rotations();
		for (int i = 0; i < FFT_LEN; i++) begin
			frame_re[i] = 0;
			frame_im[i] = 0;
		end
		samples_in = 0;
		spectrum_valid = 0;
		fails = 0;
	end

	assign pending = read_results.size();

	// compare responses, then predict from accepted requests
	always @(posedge clk) begin
		fps_rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (read_results.size() == 0) begin
					$error("response with no read outstanding");
					fails++;
				end else begin
					want = read_results.pop_front();
					if (rsp.power !== want.power) begin
						$error("power: expected %0d, got %0d", want.power, rsp.power);
						fails++;
					end
					if (rsp.bin_out !== want.bin_out) begin
						$error("bin_out: expected %0d, got %0d", want.bin_out, rsp.bin_out);
						fails++;
					end
					if (rsp.ready_res !== want.ready_res) begin
						$error("ready_res: expected %0d, got %0d",
							want.ready_res, rsp.ready_res);
						fails++;
					end
				end
			end
			if (req_valid && req_ready) begin
				if (req.func == REQ_PUSH) begin
					if (samples_in < FFT_LEN) begin
						frame_re[samples_in] = longint'(req.sample) <<< (DATA_W - 16);
						frame_im[samples_in] = 0;
					end
					samples_in++;
					if (samples_in >= FRAME_LEN) begin
						run_spectrum();
						samples_in = 0;
						spectrum_valid = 1;
					end
				end else begin
					want.bin_out   = req.bin;
					want.ready_res = spectrum_valid;
					want.power     = spectrum_valid ? PWR_W'(bin_power[req.bin]) : '0;
					read_results.push_back(want);
				end
			end
		end
	end
endmodule

@@ tb/tb.sv @@
// Stimulus and verdict for the power spectrum block
module tb;
	import fps_pkg::*;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_READ = 1'b1;
	localparam int   RAND_ITEMS = 1750;
	localparam int   CYCLE_LIMIT = 3000000;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	fps_req_t req;
	logic     rsp_valid;
	logic     rsp_ready;
	fps_rsp_t rsp;
	int       fails;
	int       pending;
	int       send_idle_pct;
	int       recv_stall_pct;
	int       phase;
	int       cycles;

	fft512_power_spectrum dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	fps_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.fails(fails), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// hold or take responses; one long hold-off at the start of the last phase
	initial begin
		bit held;
		held = 0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (phase == 2 && !held) begin
				held = 1;
				rsp_ready = 1'b0;
				repeat (4000) @(negedge clk);
			end
			rsp_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// offer one request and hold it until taken; called at a falling edge
	task automatic offer(logic fn, logic signed [SMP_W-1:0] smp, logic [BIN_W-1:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req.func = fn;
		req.sample = smp;
		req.bin = b;
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	function automatic logic signed [SMP_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return SMP_W'($urandom_range(0, 63) - 32);
			default: return SMP_W'($urandom);
		endcase
	endfunction

	initial begin
		cycles = 0;
		phase = 0;
		send_idle_pct = 28;
		recv_stall_pct = 73;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reads before any frame, bin extremes
		offer(REQ_READ, 16'sh0, 9'd0);
		offer(REQ_READ, 16'sh5a5a, 9'd511);
		offer(REQ_READ, 16'sh0, 9'd256);
		// sample extremes at the head of the first frame
		offer(REQ_PUSH, 16'sh7fff, 9'h1ff);
		offer(REQ_PUSH, 16'sh8000, 9'h0);
		offer(REQ_PUSH, 16'sh0, 9'h0);
		offer(REQ_PUSH, 16'shffff, 9'h0);
		offer(REQ_PUSH, 16'sh0001, 9'h0);
		offer(REQ_READ, 16'sh0, 9'd1);

		// random mix of pushes and reads over three idling phases
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS / 3) begin
				phase = 1;
				send_idle_pct = 73;
				recv_stall_pct = 28;
			end else if (n == 2 * RAND_ITEMS / 3) begin
				phase = 2;
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			if ($urandom_range(99) < 40)
				offer(REQ_READ, SMP_W'($urandom), BIN_W'($urandom_range(0, 511)));
			else
				offer(REQ_PUSH, pick_sample(), BIN_W'($urandom));
		end
		req_valid = 1'b0;

		// drain outstanding reads, then let the engine settle
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
